// ----- hw/rtl/b64e_pkg.sv -----
// b64e_pkg: shared types, constants and the symbol lookup for the base64url token encoder
// used by every module under hw/rtl; depends on nothing
package b64e_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_D   = 8'h64;
	localparam logic [7:0] CH_E   = 8'h65;
	localparam logic [7:0] CH_V   = 8'h76;

	// suffix character codes, in emit order after a group
	typedef enum logic [1:0] {
		SFX_DOT = 2'd0,
		SFX_D   = 2'd1,
		SFX_E   = 2'd2,
		SFX_V   = 2'd3
	} sfx_t;

	// one unit of work for the back end
	typedef struct packed {
		logic        has_group;
		logic [23:0] group;
		logic        has_dot;
		logic        has_dev;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		priority if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2D;
		end else begin
			c = 8'h5F;
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/b64e_fifo.sv -----
// b64e_fifo: short job queue between front and back end
// depends on b64e_pkg (job_t, q_stat_t, queue depth)
module b64e_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b64e_pkg::job_t     push_data,
	input  logic               pop,
	output b64e_pkg::job_t     head,
	output b64e_pkg::q_stat_t  stat
);
	import b64e_pkg::*;

	job_t            mem_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (count_q == QCW'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/b64e_front.sv -----
// b64e_front: accepts input transactions, gathers bytes into groups and builds jobs
// depends on b64e_pkg (job_t, q_stat_t)
module b64e_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               byte_present,
	input  logic               segment_end,
	input  logic               segment_kind,
	input  b64e_pkg::q_stat_t  q_stat,
	output logic               push,
	output b64e_pkg::job_t     job
);
	import b64e_pkg::*;

	logic [15:0] held_bytes_q;
	logic [1:0]  held_count_q;
	logic [15:0] held_n;
	logic [1:0]  cnt_n;
	logic        accept;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;

	always_comb begin
		job    = '0;
		held_n = held_bytes_q;
		cnt_n  = held_count_q;
		if (byte_present) begin
			if (held_count_q == 2'd2) begin
				job.has_group = 1'b1;
				job.group     = {held_bytes_q, data_byte};
				held_n        = '0;
				cnt_n         = 2'd0;
			end else begin
				held_n = {held_bytes_q[7:0], data_byte};
				cnt_n  = held_count_q + 2'd1;
			end
		end
		if (segment_end) begin
			// flush a short group, zero filled
			if (cnt_n == 2'd1) begin
				job.has_group = 1'b1;
				job.group     = {held_n[7:0], 16'h0000};
			end else if (cnt_n == 2'd2) begin
				job.has_group = 1'b1;
				job.group     = {held_n, 8'h00};
			end
			job.has_dot = 1'b1;
			job.has_dev = segment_kind;
			held_n      = '0;
			cnt_n       = 2'd0;
		end
	end

	assign push = accept && (job.has_group || job.has_dot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes_q <= '0;
			held_count_q <= '0;
		end else if (accept) begin
			held_bytes_q <= held_n;
			held_count_q <= cnt_n;
		end
	end

endmodule

// ----- hw/rtl/b64e_back.sv -----
// b64e_back: walks the head job one character per cycle into the output register while out_stall is low
// depends on b64e_pkg (job_t, q_stat_t, b64_char, suffix characters)
module b64e_back (
	input  logic               clk,
	input  logic               arst_n,
	input  b64e_pkg::job_t     head,
	input  b64e_pkg::q_stat_t  q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_char,
	output logic               last_of_run
);
	import b64e_pkg::*;

	logic [2:0] pos_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       last_q;
	logic       adv;
	logic       load;
	logic       at_last;
	logic [3:0] n_chars;
	logic [2:0] last_idx;
	logic [2:0] grp_len;
	logic [2:0] sfx_len;
	logic [5:0] sextet;
	logic [2:0] sfx_pos;
	sfx_t       sfx;
	logic [7:0] next_char;

	assign grp_len  = head.has_group ? 3'd4 : 3'd0;
	assign sfx_len  = head.has_dot ? (head.has_dev ? 3'd4 : 3'd1) : 3'd0;
	assign n_chars  = {1'b0, grp_len} + {1'b0, sfx_len};
	assign last_idx = 3'(n_chars - 4'd1);
	assign at_last  = (pos_q == last_idx);

	assign adv  = !out_valid_q || !out_stall;
	assign load = adv && !q_stat.empty;
	assign pop  = load && at_last;

	always_comb begin
		unique case (pos_q[1:0])
			2'd0:    sextet = head.group[23:18];
			2'd1:    sextet = head.group[17:12];
			2'd2:    sextet = head.group[11:6];
			default: sextet = head.group[5:0];
		endcase
		sfx_pos = pos_q - grp_len;
		sfx     = sfx_t'(sfx_pos[1:0]);
		if (head.has_group && !pos_q[2]) begin
			next_char = b64_char(sextet);
		end else begin
			unique case (sfx)
				SFX_DOT: next_char = CH_DOT;
				SFX_D:   next_char = CH_D;
				SFX_E:   next_char = CH_E;
				SFX_V:   next_char = CH_V;
				default: next_char = CH_DOT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= !q_stat.empty;
			if (load) begin
				pos_q <= at_last ? 3'd0 : pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= next_char;
			last_q     <= at_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last_of_run = last_q;

endmodule

// ----- hw/rtl/base64url_token_encoder.sv -----
// base64url_token_encoder: top level of the token encoder
// depends on b64e_pkg, b64e_front, b64e_fifo, b64e_back
//
// Usage:
//   Input channel (in_valid/in_stall) carries one byte of segment text per
//   transaction (byte_present) plus segment_end and segment_kind. Every three
//   bytes give four base64url characters; a segment end flushes a short group
//   zero filled, then emits '.', and for a payload segment also "dev".
//   Output channel (out_valid/out_stall) carries one character per
//   transaction; last_of_run marks the final character of an input item.
//   The first character of an item passes through the job queue and then the
//   output register. The output register gives one character per cycle while
//   out_stall is low; an item makes 0, 1, 4, 5 or 8 characters, and items with
//   no characters are not queued. The back end walking characters sets this rate.
//   A four-entry job queue lets the input keep accepting while characters
//   drain; in_stall rises only when that queue is full.
//   When the receiver stalls, the output holds its character and the queue
//   fills. Reset (arst_n low) empties the queue and clears held bytes.
module base64url_token_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       byte_present,
	input  logic       segment_end,
	input  logic       segment_kind,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_of_run
);
	import b64e_pkg::*;

	job_t    push_job;
	job_t    head_job;
	q_stat_t q_stat;
	logic    push;
	logic    pop;

	b64e_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.segment_end  (segment_end),
		.segment_kind (segment_kind),
		.q_stat       (q_stat),
		.push         (push),
		.job          (push_job)
	);

	b64e_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.head      (head_job),
		.stat      (q_stat)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_job),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule

// ----- hw/rtl/b64e_checker.sv -----
// b64e_checker: port-level assertions for the token encoder, bound to the top level
// depends on b64e_pkg (suffix characters)
module b64e_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] data_byte,
	input logic       byte_present,
	input logic       segment_end,
	input logic       segment_kind,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_char,
	input logic       last_of_run
);
	import b64e_pkg::*;

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_of_run))
		else $error("stalled output changed");

	// a run that is not finished keeps going in the next cycle
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("gap inside a run");

	// a separator that is not last is followed by the signature
	a_dot_dev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_char == CH_DOT && !last_of_run
		|=> out_valid && out_char == CH_D)
		else $error("separator not followed by signature");

	// separator with signature: after 'd' comes 'e', which is not last
	a_dev_e: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_char == CH_D
		&& $past(out_valid && !out_stall && out_char == CH_DOT && !last_of_run)
		|=> out_valid && out_char == CH_E && !last_of_run)
		else $error("broken signature");

endmodule

bind base64url_token_encoder b64e_checker u_b64e_checker (.*);

// ----- test/base64url_token_encoder_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for base64url_token_encoder: directed and random segments
// go through a scoreboard class that predicts every token character; depends on b64e_pkg

class token_scoreboard;
	logic [15:0] held_bytes;
	logic [1:0]  held_count;
	logic [7:0]  expected_chars[$];
	logic        expected_lasts[$];
	int          mismatches;

	function new();
		held_bytes = '0;
		held_count = '0;
		mismatches = 0;
	endfunction

	function logic [7:0] symbol(logic [5:0] v);
		string alphabet;
		alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
		return alphabet[v];
	endfunction

	function void push_char(logic [7:0] ch);
		expected_chars.push_back(ch);
		expected_lasts.push_back(1'b0);
	endfunction

	function void push_group(logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
		push_char(symbol(b1[7:2]));
		push_char(symbol({b1[1:0], b2[7:4]}));
		push_char(symbol({b2[3:0], b3[7:6]}));
		push_char(symbol(b3[5:0]));
	endfunction

	// an accepted input transaction
	function void note_item(logic [7:0] data, logic present, logic seg_end, logic payload);
		int first;
		first = expected_chars.size();
		if (present) begin
			if (held_count == 2'd2) begin
				push_group(held_bytes[15:8], held_bytes[7:0], data);
				held_bytes = '0;
				held_count = '0;
			end else begin
				held_bytes = {held_bytes[7:0], data};
				held_count = held_count + 2'd1;
			end
		end
		if (seg_end) begin
			if (held_count == 2'd1)
				push_group(held_bytes[7:0], 8'h00, 8'h00);
			else if (held_count == 2'd2)
				push_group(held_bytes[15:8], held_bytes[7:0], 8'h00);
			held_bytes = '0;
			held_count = '0;
			push_char(b64e_pkg::CH_DOT);
			if (payload) begin
				push_char(b64e_pkg::CH_D);
				push_char(b64e_pkg::CH_E);
				push_char(b64e_pkg::CH_V);
			end
		end
		if (expected_chars.size() > first)
			expected_lasts[expected_lasts.size() - 1] = 1'b1;
	endfunction

	task report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// an accepted output transaction
	task check_char(logic [7:0] ch, logic last);
		logic [7:0] want_ch;
		logic       want_last;
		if (expected_chars.size() == 0) begin
			report_mismatch($sformatf("unexpected char %h last %b", ch, last));
			return;
		end
		want_ch = expected_chars.pop_front();
		want_last = expected_lasts.pop_front();
		if (ch !== want_ch)
			report_mismatch($sformatf("out_char %h, want %h", ch, want_ch));
		if (last !== want_last)
			report_mismatch($sformatf("last_of_run %b, want %b (char %h)", last, want_last,
				want_ch));
	endtask
endclass

module base64url_token_encoder_test;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;
	localparam int RANDOM_ITEMS = 80;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       segment_end;
	logic       segment_kind;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_char;
	logic       last_of_run;

	token_scoreboard sb;
	int  cycles;
	int  items_sent;
	bit  sender_steady;
	bit  receiver_steady;
	bit  hold_request;

	base64url_token_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.byte_present(byte_present),
		.segment_end (segment_end),
		.segment_kind(segment_kind),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task send_item(logic [7:0] data, logic present, logic seg_end, logic kind);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_byte = data;
		byte_present = present;
		segment_end = seg_end;
		segment_kind = kind;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(data, present, seg_end, kind);
		items_sent++;
		@(negedge clk);
	endtask

	task send_segment(int nbytes, logic kind, logic bare_end);
		logic closes;
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
			closes = (i == nbytes - 1) && !bare_end;
			send_item(8'($urandom_range(0, 255)), 1'b1, closes,
				closes ? kind : logic'($urandom_range(0, 1)));
		end
		if (bare_end || nbytes == 0)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, kind);
	endtask

	task drain_output();
		in_valid = 1'b0;
		while (sb.expected_chars.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task run_directed();
		send_item(8'hFF, 1'b0, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0, 1'b0);
		send_item(8'h55, 1'b0, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0, 1'b1);
		send_item(8'h80, 1'b1, 1'b0, 1'b0);
		send_item(8'hAA, 1'b0, 1'b1, 1'b0);
		send_item(8'hFB, 1'b1, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0, 1'b0);
		send_item(8'hBF, 1'b1, 1'b1, 1'b1);
		send_item(8'h01, 1'b1, 1'b0, 1'b0);
		send_item(8'h7F, 1'b1, 1'b0, 1'b0);
		send_item(8'hFE, 1'b1, 1'b0, 1'b0);
		send_item(8'h10, 1'b1, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b1, 1'b0);
		send_item(8'h3C, 1'b1, 1'b0, 1'b1);
		send_item(8'hC3, 1'b1, 1'b1, 1'b1);
		drain_output();
	endtask

	task run_random();
		int target;
		int round;
		int pick;
		target = items_sent + RANDOM_ITEMS;
		round = 0;
		while (items_sent < target) begin
			sender_steady = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 9);
			if (round == 3) begin
				// receiver holds off while the input keeps coming
				sender_steady = 1'b1;
				hold_request = 1'b1;
				for (int i = 0; i < 14; i++)
					send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1,
						1'($urandom_range(0, 1)));
			end else if (round == 6) begin
				drain_output();
			end else if (pick < 7) begin
				send_segment($urandom_range(0, 7) == 0 ? $urandom_range(8, 12) :
					$urandom_range(0, 6), 1'b0, 1'($urandom_range(0, 1)));
				send_segment($urandom_range(0, 7) == 0 ? $urandom_range(8, 12) :
					$urandom_range(0, 6), 1'b1, 1'($urandom_range(0, 1)));
			end else if (pick < 9) begin
				send_segment($urandom_range(0, 8), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else begin
				repeat (4)
					send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			round++;
		end
		sender_steady = 1'b0;
	endtask

	initial begin
		sb = new();
		items_sent = 0;
		sender_steady = 1'b0;
		receiver_steady = 1'b0;
		hold_request = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		byte_present = 1'b0;
		segment_end = 1'b0;
		segment_kind = 1'b0;
		out_stall = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_directed();
		run_random();
		in_valid = 1'b0;
		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// output side
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				if ($urandom_range(0, 23) == 0)
					receiver_steady = !receiver_steady;
				gap = receiver_steady ? 0 : $urandom_range(0, 19);
				if (gap > 0) begin
					out_stall = 1'b1;
					repeat (gap) @(negedge clk);
				end
			end
			out_stall = 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_char(out_char, last_of_run);
			@(negedge clk);
		end
	end
endmodule
